>>> rtl/averaged_moisture_pump_hysteresis_macros.svh
`ifndef AVERAGED_MOISTURE_PUMP_HYSTERESIS_MACROS_SVH
`define AVERAGED_MOISTURE_PUMP_HYSTERESIS_MACROS_SVH

// Assertion shorthands. Both expect clk_i and rst_ni in the enclosing scope.

// A property that must hold at every clock edge outside reset.
`define AMPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define AMPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/amph_pkg.sv
package amph_pkg;

  // Field widths.
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned LVL_W     = 16;
  localparam int unsigned DES_W     = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // Default window length.
  localparam int unsigned WINDOW_DEF = 5;

  // Shared divider: dividend magnitude and divisor widths, step counter width.
  localparam int unsigned MAG_W  = 32;
  localparam int unsigned DVS_W  = 16;
  localparam int unsigned STEP_W = $clog2(MAG_W + 1);

  // Multiplier operand width (signed) and product width.
  localparam int unsigned MUL_W  = 17;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // floor(x / 5) for x below 2**17 equals (x * RECIP_5) >> RECIP_SH.
  localparam int unsigned THR_X_W  = DES_W + 2;
  localparam int unsigned RECIP_W  = 16;
  localparam logic [RECIP_W-1:0] RECIP_5 = 16'd52429;
  localparam int unsigned RECIP_SH = 18;

  // Register reset values.
  localparam logic signed [LVL_W-1:0] OUT_LOW_RST  = 16'sd0;
  localparam logic signed [LVL_W-1:0] OUT_HIGH_RST = 16'sd100;
  localparam logic [RAW_W-1:0]        IN_LOW_RST   = 16'd236;
  localparam logic [RAW_W-1:0]        IN_HIGH_RST  = 16'd655;
  localparam logic [DES_W-1:0]        DESIRED_RST  = 15'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_LOW     = 3'd0,
    REG_OUT_HIGH    = 3'd1,
    REG_IN_LOW      = 3'd2,
    REG_IN_HIGH     = 3'd3,
    REG_MAP_INVERSE = 3'd4,
    REG_DESIRED     = 3'd5
  } amph_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_MAP_PREP,
    ST_MUL_BASE,
    ST_MUL_SPAN,
    ST_SUM,
    ST_MAP_START,
    ST_MAP_WAIT,
    ST_FINISH
  } amph_state_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/amph_divider.sv
module amph_divider #(
  parameter int unsigned DVD_W = amph_pkg::MAG_W,
  parameter int unsigned DVS_W = amph_pkg::DVS_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  amph_pkg::div_ctrl_t ctrl_i,
  input  logic [DVD_W-1:0]    dividend_i,
  input  logic [DVS_W-1:0]    divisor_i,
  output amph_pkg::div_stat_t status_o,
  output logic [DVD_W-1:0]    quotient_o
);
  import amph_pkg::*;

  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  divisor_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;
  logic [DVS_W-1:0]  rem_d;

  // One restoring step: the quotient bit shifts in at the bottom of the
  // dividend register, so a left-aligned dividend yields the quotient there.
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, divisor_q};
    fits  = (trial >= {1'b0, divisor_q});
    rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (ctrl_i.start) begin
      cnt_q  <= ctrl_i.steps;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == STEP_W'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q     <= '0;
      dvd_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
    end
  end

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;
  assign quotient_o    = dvd_q;

endmodule

>>> rtl/averaged_moisture_pump_hysteresis.sv
// Soil moisture conditioner. Each raw capacitance item enters a window of the
// last WINDOW samples; the block reports the truncated running average over
// the samples seen so far (up to WINDOW), that average clamped to
// [in_low, in_high] and mapped linearly (or inversely when map_inverse is set)
// onto [out_low, out_high] with the quotient truncated toward zero, and a pump
// drive with hysteresis: it switches on when the scaled level falls below
// 60 percent of desired_level (floored) and off when it rises above
// desired_level. An empty input range (in_high <= in_low) yields out_low.
// The block handles one item at a time. How long an item takes is set mostly
// by the shared serial divider, which yields one quotient bit per cycle and
// runs twice per item, first for the average and then for the 32-bit map
// quotient; a single shared multiplier forms the two map products in
// consecutive cycles. An empty input range skips the map and its second
// division. The next item can be accepted in the cycle after the result is
// loaded. in_stall_o stays high from acceptance until the result is loaded
// into the output register, and a new item is accepted while that result
// still waits to be taken. Configuration writes are always ready; they are
// meant to be made while the block is idle.

`include "averaged_moisture_pump_hysteresis_macros.svh"

module averaged_moisture_pump_hysteresis #(
  parameter int unsigned WINDOW = amph_pkg::WINDOW_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Input items.
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [amph_pkg::RAW_W-1:0]              raw_sample_i,
  // Result items.
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [amph_pkg::RAW_W-1:0]              averaged_raw_o,
  output logic signed [amph_pkg::LVL_W-1:0]       scaled_level_o,
  output logic                                    pump_on_o,
  // Configuration writes.
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [amph_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [amph_pkg::CFG_DAT_W-1:0]          cfg_data_i
);
  import amph_pkg::*;

  // Window bookkeeping widths. The sum of WINDOW 16-bit samples needs
  // clog2(WINDOW) extra bits; the fill count must hold WINDOW itself.
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = RAW_W + $clog2(WINDOW);
  localparam int unsigned NUM_W  = PROD_W + 1;

  // Configuration registers.
  logic signed [LVL_W-1:0] out_low_q;
  logic signed [LVL_W-1:0] out_high_q;
  logic [RAW_W-1:0]        in_low_q;
  logic [RAW_W-1:0]        in_high_q;
  logic                    map_inverse_q;
  logic [DES_W-1:0]        desired_q;
  logic [DES_W-1:0]        thresh_q;

  // Control state.
  amph_state_e             state_q, state_d;
  logic [FILL_W-1:0]       fill_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [SUM_W-1:0]        sum_q;
  logic                    out_valid_q;
  logic                    pump_q;

  // Sample window, written once per item, read at the current slot.
  logic [RAW_W-1:0]        win_q [WINDOW];

  // Datapath registers.
  logic [RAW_W-1:0]        avg_q;
  logic [RAW_W-1:0]        off_q;
  logic [RAW_W-1:0]        den_q;
  logic signed [MUL_W-1:0] span_q;
  logic signed [PROD_W-1:0] p_base_q;
  logic signed [PROD_W-1:0] p_span_q;
  logic signed [NUM_W-1:0] num_q;
  logic                    neg_q;
  logic signed [LVL_W-1:0] scaled_q;
  logic [RAW_W-1:0]        out_avg_q;
  logic signed [LVL_W-1:0] out_scaled_q;

  // Combinational helpers.
  logic                    in_accept;
  logic                    out_free;
  logic                    win_full;
  logic                    range_empty;
  logic [SUM_W-1:0]        sum_d;
  logic [RAW_W-1:0]        clamp_x;
  logic [THR_X_W-1:0]      thr_x;
  logic [THR_X_W+RECIP_W-1:0] thr_prod;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [NUM_W-1:0] num_abs;
  logic [MAG_W-1:0]        div_dividend;
  logic [DVS_W-1:0]        div_divisor;
  logic [MAG_W-1:0]        div_quot;
  div_ctrl_t               div_ctrl;
  div_stat_t               div_stat;
  logic                    pump_d;
  logic                    load_out;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign win_full    = (fill_q == FILL_W'(WINDOW));
  assign range_empty = (in_high_q <= in_low_q);
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers. The pump-on threshold floor(0.6 * desired) is
  // derived here by a reciprocal multiply and kept in a register of its own.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_low_q     <= OUT_LOW_RST;
      out_high_q    <= OUT_HIGH_RST;
      in_low_q      <= IN_LOW_RST;
      in_high_q     <= IN_HIGH_RST;
      map_inverse_q <= 1'b0;
      desired_q     <= DESIRED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (amph_reg_e'(cfg_index_i))
        REG_OUT_LOW:     out_low_q     <= $signed(cfg_data_i[LVL_W-1:0]);
        REG_OUT_HIGH:    out_high_q    <= $signed(cfg_data_i[LVL_W-1:0]);
        REG_IN_LOW:      in_low_q      <= cfg_data_i[RAW_W-1:0];
        REG_IN_HIGH:     in_high_q     <= cfg_data_i[RAW_W-1:0];
        REG_MAP_INVERSE: map_inverse_q <= cfg_data_i[0];
        REG_DESIRED:     desired_q     <= cfg_data_i[DES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    thr_x    = THR_X_W'(desired_q) + THR_X_W'({desired_q, 1'b0});
    thr_prod = thr_x * RECIP_5;
  end

  always_ff @(posedge clk_i) begin
    thresh_q <= thr_prod[RECIP_SH +: DES_W];
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_accept) state_d = ST_AVG_START;
      ST_AVG_START: state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (div_stat.done) begin
          state_d = range_empty ? ST_FINISH : ST_MAP_PREP;
        end
      end
      ST_MAP_PREP:  state_d = ST_MUL_BASE;
      ST_MUL_BASE:  state_d = ST_MUL_SPAN;
      ST_MUL_SPAN:  state_d = ST_SUM;
      ST_SUM:       state_d = ST_MAP_START;
      ST_MAP_START: state_d = ST_MAP_WAIT;
      ST_MAP_WAIT:  if (div_stat.done) state_d = ST_FINISH;
      ST_FINISH:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs toward the shared divider and multiplier.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall_o     = (state_q != ST_IDLE);
    load_out       = (state_q == ST_FINISH) && out_free;
    div_ctrl.start = 1'b0;
    div_ctrl.steps = STEP_W'(MAG_W);
    // The average is left-aligned so that only SUM_W steps are needed.
    div_dividend   = MAG_W'(sum_q) << (MAG_W - SUM_W);
    div_divisor    = DVS_W'(fill_q);
    mul_a          = MUL_W'(map_inverse_q ? out_high_q : out_low_q);
    mul_b          = $signed({1'b0, den_q});
    case (state_q)
      ST_AVG_START: begin
        div_ctrl.start = 1'b1;
        div_ctrl.steps = STEP_W'(SUM_W);
      end
      ST_MUL_SPAN: begin
        mul_a = span_q;
        mul_b = $signed({1'b0, off_q});
      end
      ST_MAP_START: begin
        div_ctrl.start = 1'b1;
        div_dividend   = num_abs[MAG_W-1:0];
        div_divisor    = den_q;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  amph_divider #(
    .DVD_W (MAG_W),
    .DVS_W (DVS_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .status_o   (div_stat),
    .quotient_o (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Window update. The oldest sample leaves the sum only once the window has
  // filled; before that the slot simply tracks the fill count.
  // ---------------------------------------------------------------------------
  always_comb begin
    sum_d = sum_q - (win_full ? SUM_W'(win_q[slot_q]) : SUM_W'(0))
                  + SUM_W'(raw_sample_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      slot_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      pump_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        sum_q  <= sum_d;
        slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
        if (!win_full) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        pump_q      <= pump_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      win_q[slot_q] <= raw_sample_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Map datapath.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (avg_q < in_low_q) begin
      clamp_x = in_low_q;
    end else if (avg_q > in_high_q) begin
      clamp_x = in_high_q;
    end else begin
      clamp_x = avg_q;
    end
    // The quotient lies between out_low and out_high, so the magnitude of the
    // numerator stays below 2**31 and fits the divider.
    num_abs = num_q[NUM_W-1] ? -num_q : num_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_AVG_WAIT: begin
        if (div_stat.done) begin
          avg_q    <= div_quot[RAW_W-1:0];
          scaled_q <= out_low_q;
        end
      end
      ST_MAP_PREP: begin
        off_q  <= clamp_x - in_low_q;
        den_q  <= in_high_q - in_low_q;
        span_q <= MUL_W'(out_high_q) - MUL_W'(out_low_q);
      end
      ST_MUL_BASE: p_base_q <= mul_p;
      ST_MUL_SPAN: p_span_q <= mul_p;
      ST_SUM: begin
        num_q <= map_inverse_q ? (NUM_W'(p_base_q) - NUM_W'(p_span_q))
                               : (NUM_W'(p_base_q) + NUM_W'(p_span_q));
      end
      ST_MAP_START: neg_q <= num_q[NUM_W-1];
      ST_MAP_WAIT: begin
        if (div_stat.done) begin
          scaled_q <= neg_q ? -$signed(div_quot[LVL_W-1:0])
                            : $signed(div_quot[LVL_W-1:0]);
        end
      end
      default: ;
    endcase
  end

  // Hysteresis: switching off above the target wins over switching on.
  always_comb begin
    if (scaled_q > $signed({1'b0, desired_q})) begin
      pump_d = 1'b0;
    end else if (scaled_q < $signed({1'b0, thresh_q})) begin
      pump_d = 1'b1;
    end else begin
      pump_d = pump_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_avg_q    <= avg_q;
      out_scaled_q <= scaled_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign averaged_raw_o = out_avg_q;
  assign scaled_level_o = out_scaled_q;
  assign pump_on_o      = pump_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `AMPH_ASSERT_NEXT(a_accept_blocks, in_accept, in_stall_o, "input taken while busy")
  `AMPH_ASSERT(a_slot_tracks_fill, !win_full |-> (FILL_W'(slot_q) == fill_q),
    "write slot and fill count disagree before the window is full")
  `AMPH_ASSERT(a_div_idle, (state_q == ST_IDLE) |-> !div_stat.busy,
    "divider still running while the block is idle")
  `AMPH_ASSERT(a_result_source, $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH),
    "result raised outside the finish step")

endmodule
